// File: hw/rtl/shamh_pkg.sv
// shared types, round constants and hash functions of the sha-256 message hasher
package shamh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	// control from the sequencer to the round datapath
	typedef struct packed {
		logic start;   // load working variables from the hash state
		logic step;    // run one compression round
		logic update;  // fold working variables into the hash state
		logic reinit;  // return the hash state to the initial values
	} round_ctl_t;

	// control from the sequencer to the message schedule
	typedef struct packed {
		logic       load;    // write one message byte
		logic [5:0] pos;     // byte offset in the block
		logic [7:0] data;    // byte to write
		logic       step;    // advance the schedule window by one round
		logic       expand;  // round 16 or later: compute a new schedule word
	} sched_ctl_t;

	localparam int unsigned ROUNDS = 64;
	localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [2:0] LAST_IDX = 3'd7;

	localparam word_t K_TAB [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam word_t IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: hw/rtl/shamh_sched.sv
// message schedule: block buffer filled byte by byte, sliding window during rounds
module shamh_sched (
	input  logic                   clk,
	input  shamh_pkg::sched_ctl_t  ctl,
	output shamh_pkg::word_t       w
);
	import shamh_pkg::*;

	word_t      win_q [16];
	word_t      w_new;
	logic [4:0] sh;
	word_t      byte_word;

	assign w_new = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);
	assign w = ctl.expand ? w_new : win_q[0];

	// big-endian placement within the word
	assign sh = {~ctl.pos[1:0], 3'b000};
	assign byte_word = {24'b0, ctl.data} << sh;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 16; i++) begin
				if (ctl.pos[5:2] == 4'(i)) begin
					if (ctl.pos[1:0] == 2'b00) begin
						win_q[i] <= byte_word;
					end else begin
						win_q[i] <= win_q[i] | byte_word;
					end
				end
			end
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w;
		end
	end

endmodule

// File: hw/rtl/shamh_round.sv
// compression round unit: working variables and hash state
module shamh_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shamh_pkg::round_ctl_t  ctl,
	input  shamh_pkg::word_t       k,
	input  shamh_pkg::word_t       w,
	output shamh_pkg::hash_t       hash
);
	import shamh_pkg::*;

	hash_t hash_q;
	hash_t var_q;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	// var_q[0] is a, var_q[7] is h
	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1  = var_q[7] + big_sigma1(var_q[4]) + ch + k + w;
	assign t2  = big_sigma0(var_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			var_q <= hash_q;
		end else if (ctl.step) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV_TAB[i];
			end
		end else if (ctl.reinit) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV_TAB[i];
			end
		end else if (ctl.update) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + var_q[i];
			end
		end
	end

	assign hash = hash_q;

endmodule

// File: hw/rtl/sha256_message_hasher_unit.sv
// top level of the byte-serial sha-256 message hasher
// Byte-serial SHA-256 hasher. Message bytes come in one per input transaction and are
// packed big-endian into a 512-bit block. The byte that completes a block starts the
// compression: one shared round unit runs the 64 rounds one per cycle, then folds the
// result into the hash state, and input ready stays low during compression. A
// transaction with end_of_message set starts padding: the 0x80 marker, zero fill and
// the 64-bit bit length are written one byte per cycle through the same path, pausing
// while each filled block is compressed. The eight digest words H0..H7 then leave as
// eight output transactions, last_word set on H7, after which the hash state returns
// to the initial values and the block accepts a new message. An end marker with
// byte_valid low finishes the message with the bytes so far (an empty message if
// there were none); a transaction with both flags low is taken and ignored.
module sha256_message_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shamh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t      state_q;
	logic [5:0]  pos_q;      // byte offset in the current block
	logic [60:0] bytes_q;    // message length in bytes, bit length is this times 8
	logic [5:0]  rnd_q;      // round counter
	logic [2:0]  idx_q;      // digest word being sent
	logic        pad_q;      // padding still in progress after this compression
	logic        fin_q;      // this compression is the last block of the message
	logic        mark_q;     // 0x80 marker already written
	logic        len_q;      // writing the length field

	round_ctl_t  rctl;
	sched_ctl_t  wctl;
	hash_t       hash;
	word_t       w;
	logic [63:0] bit_len;
	logic        in_acc;
	logic        out_acc;
	logic        len_now;
	logic [7:0]  pad_byte;
	logic        block_full;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign bit_len = {bytes_q, 3'b000};

	// padding byte: marker first, then zeros, then the length from offset 56 on
	assign len_now = mark_q && (len_q || (pos_q == LEN_POS));
	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_now) begin
			pad_byte = bit_len[6'(7 - pos_q[2:0]) * 8 +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// a byte written at the last offset closes the block
	assign block_full = (pos_q == LAST_POS);

	always_comb begin
		wctl        = '0;
		wctl.pos    = pos_q;
		wctl.data   = (state_q == ST_PAD) ? pad_byte : data_byte;
		wctl.load   = (in_acc && byte_valid) || (state_q == ST_PAD);
		wctl.step   = (state_q == ST_ROUND);
		wctl.expand = |rnd_q[5:4];

		rctl        = '0;
		rctl.start  = wctl.load && block_full;
		rctl.step   = (state_q == ST_ROUND);
		rctl.update = (state_q == ST_UPDATE);
		rctl.reinit = out_acc && (idx_q == LAST_IDX);
	end

	shamh_sched u_sched (
		.clk (clk),
		.ctl (wctl),
		.w   (w)
	);

	shamh_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.k      (K_TAB[rnd_q]),
		.w      (w),
		.hash   (hash)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			bytes_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			if (wctl.load) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pad_q  <= end_of_message;
						fin_q  <= 1'b0;
						mark_q <= 1'b0;
						len_q  <= 1'b0;
						if (byte_valid) begin
							bytes_q <= bytes_q + 61'd1;
						end
						if (byte_valid && block_full) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (len_now) begin
						len_q <= 1'b1;
					end
					if (block_full) begin
						fin_q   <= len_now;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							pos_q   <= '0;
							bytes_q <= '0;
							pad_q   <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digest words straight from the hash state
	assign digest_word = hash[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_IDX);

	// input and output never open at the same time
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest output is valid");

	// the hash update follows the last round only
	a_update_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == LAST_ROUND))
		else $error("hash update without a full round sequence");

	// the digest only leaves after the length closed a block
	a_emit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_q == '0 && len_q))
		else $error("digest output with a partial block");

	// the last digest transaction frees the input side
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (in_ready && pos_q == '0 && bytes_q == '0))
		else $error("block not ready for a new message after the digest");

endmodule

// File: tb/sha256_hasher_tb_pkg.sv
// sha-256 digest predictor and scoreboard used by the message hasher testbench
package sha256_hasher_tb_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LENGTH_OFFSET = 6'd56;
	localparam logic [2:0] FINAL_WORD = 3'd7;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	class digest_scoreboard;
		logic [31:0]  hash_state [8];
		logic [31:0]  block_words [16];
		logic [5:0]   block_pos;
		logic [63:0]  bit_length;
		digest_word_t digest_queue [$];
		int unsigned  mismatches;

		function new();
			foreach (block_words[i]) block_words[i] = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (hash_state[i]) hash_state[i] = HASH_INIT[i];
			block_pos = '0;
			bit_length = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// 64 rounds over the current block, schedule expanded in place
		function void compress();
			logic [31:0] v [8];
			logic [31:0] w, t1, t2, s0, s1, x1, x14;
			v = hash_state;
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					w = block_words[r];
				end else begin
					x1 = block_words[(r + 1) % 16];
					x14 = block_words[(r + 14) % 16];
					s0 = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
					s1 = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
					w = block_words[r % 16] + s0 + s1 + block_words[(r + 9) % 16];
					block_words[r % 16] = w;
				end
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int k = 0; k < 8; k++) hash_state[k] += v[k];
		endfunction

		// big-endian packing, compression when the block fills
		function void absorb(logic [7:0] b);
			logic [31:0] lane;
			lane = {24'h0, b} << (8 * (3 - int'(block_pos[1:0])));
			if (block_pos[1:0] == 2'd0) begin
				block_words[block_pos[5:2]] = lane;
			end else begin
				block_words[block_pos[5:2]] |= lane;
			end
			block_pos++;
			if (block_pos == 6'd0) compress();
		endfunction

		function void note_transaction(logic [7:0] data, logic has_byte, logic ends);
			logic [63:0] length;
			if (has_byte) begin
				absorb(data);
				bit_length += 64'd8;
			end
			if (!ends) return;
			length = bit_length;
			absorb(PAD_BYTE);
			while (block_pos != LENGTH_OFFSET) absorb(8'h00);
			for (int k = 0; k < 8; k++) absorb(length[63 - 8 * k -: 8]);
			for (int k = 0; k < 8; k++) begin
				digest_queue.push_back('{hash_state[k], 3'(k), 3'(k) == FINAL_WORD});
			end
			restart();
		endfunction

		function int unsigned pending();
			return digest_queue.size();
		endfunction

		function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
			digest_word_t want;
			if (digest_queue.size() == 0) begin
				$error("digest word %h (index %0d) arrived with none outstanding", word, index);
				mismatches++;
				return;
			end
			want = digest_queue.pop_front();
			if (word !== want.word) begin
				$error("digest_word: expected %h, actual %h", want.word, word);
				mismatches++;
			end
			if (index !== want.index) begin
				$error("word_index: expected %0d, actual %0d", want.index, index);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_word: expected %b, actual %b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// File: tb/sha256_message_hasher_unit_tb.sv
// testbench for the byte-serial sha-256 message hasher
module sha256_message_hasher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha256_hasher_tb_pkg::*;

	// cycle limit for the whole run, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// counted message transactions (bytes and end markers) in the random phase
	localparam int unsigned RANDOM_ITEMS = 150;
	// quiet time after the last digest word, longer than padding plus two compressions
	localparam int unsigned DRAIN_CYCLES = 400;

	// lengths around the padding boundary: length fits, just misses, full block
	localparam int unsigned EDGE_LENGTHS [5] = '{55, 56, 57, 63, 64};

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_STALLS
	} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard scoreboard = new();

	int unsigned burst_left = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int unsigned mode_left = 0;
	int unsigned stall_left = 0;

	sha256_message_hasher_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	always #5 clk = ~clk;

	// one input transaction; the sender runs in bursts and idles between them
	task automatic send_item(input logic [7:0] data, input logic has_byte, input logic ends);
		if (burst_left == 0) begin
			// gap before a new burst, valid low for a random number of cycles
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= data;
		byte_valid <= has_byte;
		end_of_message <= ends;
		// accepted at the first edge with ready high; values here are pre-edge
		do @(posedge clk); while (!in_ready);
		scoreboard.note_transaction(data, has_byte, ends);
		// ignored transactions (both flags low) do not count toward the total
		if (has_byte || ends) items_sent++;
	endtask

	// hold the sender off until every predicted digest word has come out
	task automatic wait_for_digests();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (scoreboard.pending() != 0) @(posedge clk);
	endtask

	// one message of random bytes, ended either on the last byte or by a bare end marker
	task automatic send_message(input int unsigned len, input logic bare_end);
		for (int unsigned i = 0; i < len; i++) begin
			// occasional ignored transaction in the middle of a message
			if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
		end
		// an empty message can only be ended by a bare marker
		if (len == 0 || bare_end) send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// result side: check every accepted digest word, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			scoreboard.check_digest_word(digest_word, word_index, last_word);
		end
		// the stall pattern switches at random between the three ready modes
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(20, 150);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: begin
				out_ready <= 1'b1;
			end
			READY_RANDOM: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				// ready held low for stretches of random length, broken by ready cycles
				if (stall_left == 0) begin
					out_ready <= 1'b1;
					stall_left = $urandom_range(0, 15);
				end else begin
					out_ready <= 1'b0;
					stall_left--;
				end
			end
		endcase
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned len;
		logic bare_end;

		// reset held from the start, then released once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message from a bare end marker
		send_item(8'h00, 1'b0, 1'b1);
		// ignored transaction with all data bits set, then a one-byte message of 0xff
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		// one zero byte carrying the end marker
		send_item(8'h00, 1'b1, 1'b1);
		// byte followed by a bare end marker whose data must be ignored
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		// the classic three-letter message
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// sender pauses until the hasher has delivered everything
		wait_for_digests();

		// random phase: mostly short messages, some on the padding boundary
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				len = EDGE_LENGTHS[$urandom_range(0, 4)];
			end else begin
				len = $urandom_range(0, 12);
			end
			bare_end = ($urandom_range(0, 2) == 0);
			send_message(len, bare_end);
			if ($urandom_range(0, 9) == 0) wait_for_digests();
		end

		wait_for_digests();
		// any stray digest word in this window shows up as a mismatch
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
